// File: rtl/fcr_pkg.sv
// Shared constants, types and codes of the focus chain resolver.
package fcr_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int STEP_W = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FOCUS = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [1:0] KIND_NIL = 2'd0;
  localparam logic [1:0] KIND_REF = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [31:0] SEQ_ONE = 32'd1;

  typedef enum logic [1:0] {
    OP_UPDATE,
    OP_REMOVE,
    OP_FOCUS,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] root_tree_id;
    logic [31:0] origin_tree_id;
    logic [1:0]  target_kind;
    logic [31:0] ref_tree_id;
    logic [63:0] horiz_scroll_id;
    logic [63:0] vert_scroll_id;
    logic        key_listeners;
    logic [31:0] entry_seq;
  } item_t;

  typedef struct packed {
    logic        horiz_valid;
    logic [63:0] horiz_target;
    logic        vert_valid;
    logic [63:0] vert_target;
    logic [31:0] focus_tree;
    logic        is_current;
    logic        insert_dropped;
  } result_t;

endpackage

// File: rtl/fcr_if.sv
// Valid/ready channel interfaces for requests and results.
interface fcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] root_tree_id;
  logic [31:0] origin_tree_id;
  logic [1:0]  target_kind;
  logic [31:0] ref_tree_id;
  logic [63:0] horiz_scroll_id;
  logic [63:0] vert_scroll_id;
  logic        key_listeners;
  logic [31:0] entry_seq;

  modport source (output valid, req_type, root_tree_id, origin_tree_id, target_kind,
                  ref_tree_id, horiz_scroll_id, vert_scroll_id, key_listeners,
                  entry_seq, input ready);
  modport sink (input valid, req_type, root_tree_id, origin_tree_id, target_kind,
                ref_tree_id, horiz_scroll_id, vert_scroll_id, key_listeners,
                entry_seq, output ready);
endinterface

interface fcr_out_if;
  logic        valid;
  logic        ready;
  logic        horiz_valid;
  logic [63:0] horiz_target;
  logic        vert_valid;
  logic [63:0] vert_target;
  logic [31:0] focus_tree;
  logic        is_current;
  logic        insert_dropped;

  modport source (output valid, horiz_valid, horiz_target, vert_valid, vert_target,
                  focus_tree, is_current, insert_dropped, input ready);
  modport sink (input valid, horiz_valid, horiz_target, vert_valid, vert_target,
                focus_tree, is_current, insert_dropped, output ready);
endinterface

// File: rtl/focus_chain_resolver.sv
// Top level of the focus chain resolver.
//
// Requests arrive on in_ch (valid/ready) and enter a two-item queue, so the
// sender is held off only when that queue is full. Each request produces
// exactly one result item on out_ch (valid/ready), in request order.
// cfg_wr_en/cfg_wr_data set the null scroll value; write it only while idle.
//
// A remove, a focus event or an unused code passes from the queue to the
// emit step and then the result register. An update passes through the
// update step and the resolve walk first; the walk takes at most
// TABLE_DEPTH + 1 steps (one table lookup per step, the last step of a walk
// cut at the limit does none). One item executes at a time: the next
// request leaves the queue only after the last result is loaded.
//
// Reset (rst_n low, synchronous) empties the table and the queue and drops
// any pending result. When the receiver stalls, the result register holds
// its item, execution waits in its emit step, and new requests fill the
// queue until it is full.
module focus_chain_resolver (
  input  logic        clk,
  input  logic        rst_n,
  fcr_in_if.sink      in_ch,
  fcr_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);

  logic                  q_valid;
  fcr_pkg::item_t        q_item;
  logic                  q_pop;
  logic [63:0]           null_val_r;
  fcr_pkg::result_t      res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_val_r <= '0;
    end else if (cfg_wr_en) begin
      null_val_r <= cfg_wr_data;
    end
  end

  fcr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  fcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .null_val  (null_val_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.horiz_valid = res.horiz_valid;
  assign out_ch.horiz_target = res.horiz_target;
  assign out_ch.vert_valid = res.vert_valid;
  assign out_ch.vert_target = res.vert_target;
  assign out_ch.focus_tree = res.focus_tree;
  assign out_ch.is_current = res.is_current;
  assign out_ch.insert_dropped = res.insert_dropped;

endmodule

// File: rtl/fcr_front.sv
// Request decoder and the short item queue ahead of the execution side.
module fcr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  fcr_in_if.sink               in_ch,
  output logic                 q_valid,
  output fcr_pkg::item_t       q_item,
  input  logic                 q_pop
);

  fcr_pkg::item_t                   mem_r [fcr_pkg::QUEUE_DEPTH];
  logic [fcr_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [fcr_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [fcr_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  fcr_pkg::item_t                   dec;
  logic                             push;
  logic                             pop;

  always_comb begin
    dec.root_tree_id    = in_ch.root_tree_id;
    dec.origin_tree_id  = in_ch.origin_tree_id;
    dec.target_kind     = in_ch.target_kind;
    dec.ref_tree_id     = in_ch.ref_tree_id;
    dec.horiz_scroll_id = in_ch.horiz_scroll_id;
    dec.vert_scroll_id  = in_ch.vert_scroll_id;
    dec.key_listeners   = in_ch.key_listeners;
    dec.entry_seq       = in_ch.entry_seq;
    unique case (in_ch.req_type)
      fcr_pkg::REQ_UPDATE: dec.op = fcr_pkg::OP_UPDATE;
      fcr_pkg::REQ_REMOVE: dec.op = fcr_pkg::OP_REMOVE;
      fcr_pkg::REQ_FOCUS:  dec.op = fcr_pkg::OP_FOCUS;
      default:             dec.op = fcr_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != fcr_pkg::QCNT_W'(fcr_pkg::QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_pop && q_valid;
  assign q_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/fcr_back.sv
// Entry table, resolve walk and result register.
module fcr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  fcr_pkg::item_t        q_item,
  output logic                  q_pop,
  input  logic [63:0]           null_val,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fcr_pkg::result_t      out_res
);

  localparam int D = fcr_pkg::TABLE_DEPTH;

  logic                          key_vld_r [D];
  logic [31:0]                   key_r [D];
  logic [31:0]                   ref_r [D];
  logic [63:0]                   horiz_r [D];
  logic [63:0]                   vert_r [D];
  logic [1:0]                    kind_r [D];
  logic                          lis_r [D];
  logic [31:0]                   seq_r [D];

  fcr_pkg::state_t               state_r, state_nxt;
  fcr_pkg::item_t                item_r;
  logic [fcr_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [31:0]                   local_seq_r, local_seq_nxt;
  logic [31:0]                   content_seq_r, content_seq_nxt;
  logic                          path_lis_r, path_lis_nxt;
  logic [31:0]                   cur_tree_r, cur_tree_nxt;
  logic [63:0]                   cur_h_r, cur_h_nxt;
  logic [63:0]                   cur_v_r, cur_v_nxt;
  logic                          dropped_r, dropped_nxt;
  logic                          out_vld_r, out_vld_nxt;
  fcr_pkg::result_t              res_r;
  logic                          load_out;

  logic [31:0]                   find_key;
  logic                          hit;
  logic [fcr_pkg::IDX_W-1:0]     hit_idx;
  logic                          has_free;
  logic [fcr_pkg::IDX_W-1:0]     free_idx;
  logic                          wr_en;
  logic [fcr_pkg::IDX_W-1:0]     wr_idx;
  logic                          clr_en;
  logic                          cur_ok;

  always_comb begin
    unique case (state_r)
      fcr_pkg::ST_WALK: find_key = cur_tree_r;
      fcr_pkg::ST_IDLE: find_key = q_item.origin_tree_id;
      default:          find_key = item_r.origin_tree_id;
    endcase
  end

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (key_vld_r[i] && key_r[i] == find_key) begin
        hit = 1'b1;
        hit_idx = fcr_pkg::IDX_W'(i);
      end
      if (!key_vld_r[i]) begin
        has_free = 1'b1;
        free_idx = fcr_pkg::IDX_W'(i);
      end
    end
  end

  assign cur_ok = (content_seq_r == local_seq_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    local_seq_nxt = local_seq_r;
    content_seq_nxt = content_seq_r;
    path_lis_nxt = path_lis_r;
    cur_tree_nxt = cur_tree_r;
    cur_h_nxt = cur_h_r;
    cur_v_nxt = cur_v_r;
    dropped_nxt = dropped_r;
    out_vld_nxt = out_vld_r && !out_ready;
    load_out = 1'b0;
    q_pop = 1'b0;
    wr_en = 1'b0;
    wr_idx = hit ? hit_idx : free_idx;
    clr_en = 1'b0;
    unique case (state_r)
      fcr_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          dropped_nxt = 1'b0;
          state_nxt = fcr_pkg::ST_EMIT;
          unique case (q_item.op)
            fcr_pkg::OP_UPDATE: state_nxt = fcr_pkg::ST_UPD;
            fcr_pkg::OP_REMOVE: clr_en = hit;
            fcr_pkg::OP_FOCUS:  local_seq_nxt = local_seq_r + 1'b1;
            default:            ;
          endcase
        end
      end
      fcr_pkg::ST_UPD: begin
        wr_en = hit || has_free;
        dropped_nxt = !(hit || has_free);
        step_nxt = '0;
        path_lis_nxt = 1'b0;
        cur_tree_nxt = item_r.root_tree_id;
        cur_h_nxt = null_val;
        cur_v_nxt = null_val;
        state_nxt = fcr_pkg::ST_WALK;
      end
      fcr_pkg::ST_WALK: begin
        state_nxt = fcr_pkg::ST_EMIT;
        if (step_r != fcr_pkg::STEP_W'(D) && hit) begin
          path_lis_nxt = path_lis_r | lis_r[hit_idx];
          case (kind_r[hit_idx])
            fcr_pkg::KIND_REF: begin
              if (ref_r[hit_idx] != cur_tree_r) begin
                cur_tree_nxt = ref_r[hit_idx];
                step_nxt = step_r + 1'b1;
                state_nxt = fcr_pkg::ST_WALK;
              end
            end
            fcr_pkg::KIND_SCROLL: begin
              cur_h_nxt = horiz_r[hit_idx];
              cur_v_nxt = vert_r[hit_idx];
              content_seq_nxt = seq_r[hit_idx];
              if (local_seq_r == fcr_pkg::SEQ_ONE && seq_r[hit_idx] > fcr_pkg::SEQ_ONE) begin
                local_seq_nxt = seq_r[hit_idx];
              end
            end
            default: content_seq_nxt = seq_r[hit_idx];
          endcase
        end
      end
      fcr_pkg::ST_EMIT: begin
        if (!out_vld_r || out_ready) begin
          load_out = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt = fcr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcr_pkg::ST_IDLE;
      step_r <= '0;
      local_seq_r <= fcr_pkg::SEQ_ONE;
      content_seq_r <= '0;
      path_lis_r <= 1'b0;
      cur_tree_r <= '0;
      cur_h_r <= '0;
      cur_v_r <= '0;
      dropped_r <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < D; i++) begin
        key_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      local_seq_r <= local_seq_nxt;
      content_seq_r <= content_seq_nxt;
      path_lis_r <= path_lis_nxt;
      cur_tree_r <= cur_tree_nxt;
      cur_h_r <= cur_h_nxt;
      cur_v_r <= cur_v_nxt;
      dropped_r <= dropped_nxt;
      out_vld_r <= out_vld_nxt;
      if (wr_en) begin
        key_vld_r[wr_idx] <= 1'b1;
      end else if (clr_en) begin
        key_vld_r[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (wr_en) begin
      key_r[wr_idx] <= item_r.origin_tree_id;
      ref_r[wr_idx] <= item_r.ref_tree_id;
      horiz_r[wr_idx] <= item_r.horiz_scroll_id;
      vert_r[wr_idx] <= item_r.vert_scroll_id;
      kind_r[wr_idx] <= item_r.target_kind;
      lis_r[wr_idx] <= item_r.key_listeners;
      seq_r[wr_idx] <= item_r.entry_seq;
    end
    if (load_out) begin
      res_r.horiz_valid <= cur_ok && !path_lis_r && (cur_h_r != null_val);
      res_r.horiz_target <= cur_h_r;
      res_r.vert_valid <= cur_ok && !path_lis_r && (cur_v_r != null_val);
      res_r.vert_target <= cur_v_r;
      res_r.focus_tree <= cur_tree_r;
      res_r.is_current <= cur_ok;
      res_r.insert_dropped <= dropped_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res = res_r;

endmodule

// File: rtl/fcr_checker.sv
// Port-level checks of the focus chain resolver and their binding.
module fcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        horiz_valid,
  input logic        vert_valid,
  input logic        is_current,
  input logic [63:0] horiz_target
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(horiz_target))
    else $error("Stalled result item changed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result item shown right after reset.");

  a_horiz_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && horiz_valid |-> is_current)
    else $error("Horizontal target usable while not current.");

  a_vert_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && vert_valid |-> is_current)
    else $error("Vertical target usable while not current.");

endmodule

bind focus_chain_resolver fcr_checker u_fcr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .horiz_valid  (out_ch.horiz_valid),
  .vert_valid   (out_ch.vert_valid),
  .is_current   (out_ch.is_current),
  .horiz_target (out_ch.horiz_target)
);

// File: bench/fcr_tb_if.sv
// Record type of one expected result item for the testbench checker.
package fcr_tb_pkg;

  typedef struct {
    logic        horiz_valid;
    logic [63:0] horiz_target;
    logic        vert_valid;
    logic [63:0] vert_target;
    logic [31:0] focus_tree;
    logic        is_current;
    logic        insert_dropped;
  } focus_result_t;
endpackage

// File: bench/focus_chain_checker.sv
// Checker that predicts every result of the focus chain resolver and compares it.
module focus_chain_checker (
  input  logic        clk,
  input  logic        rst_n,
  fcr_in_if           in_ch,
  fcr_out_if          out_ch,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  output int          mismatches,
  output int          pending
);
  logic        key_used [fcr_pkg::TABLE_DEPTH];
  logic [31:0] key_id [fcr_pkg::TABLE_DEPTH];
  logic [31:0] link [fcr_pkg::TABLE_DEPTH];
  logic [63:0] hz_id [fcr_pkg::TABLE_DEPTH];
  logic [63:0] vt_id [fcr_pkg::TABLE_DEPTH];
  logic [1:0]  kind_of [fcr_pkg::TABLE_DEPTH];
  logic        lis_of [fcr_pkg::TABLE_DEPTH];
  logic [31:0] seq_of [fcr_pkg::TABLE_DEPTH];
  logic [63:0] null_id;
  logic [31:0] event_seq, shown_seq, tree_now;
  logic        listeners_on_path;
  logic [63:0] horiz_now, vert_now;
  fcr_tb_pkg::focus_result_t expected_results[$];

  function automatic int lookup(logic [31:0] key);
    for (int i = 0; i < fcr_pkg::TABLE_DEPTH; i++)
      if (key_used[i] && key_id[i] == key) return i;
    return -1;
  endfunction

  task automatic walk_chain(logic [31:0] root);
    int s;
    listeners_on_path = 1'b0;
    tree_now = root;
    horiz_now = null_id;
    vert_now = null_id;
    for (int n = 0; n < fcr_pkg::TABLE_DEPTH; n++) begin
      s = lookup(tree_now);
      if (s < 0) return;
      if (lis_of[s]) listeners_on_path = 1'b1;
      if (kind_of[s] == fcr_pkg::KIND_REF) begin
        if (link[s] == tree_now) return;
        tree_now = link[s];
        continue;
      end
      shown_seq = seq_of[s];
      if (kind_of[s] == fcr_pkg::KIND_SCROLL) begin
        horiz_now = hz_id[s];
        vert_now = vt_id[s];
        if (event_seq == fcr_pkg::SEQ_ONE && shown_seq > fcr_pkg::SEQ_ONE)
          event_seq = shown_seq;
      end
      return;
    end
  endtask

  task automatic predict_item();
    fcr_tb_pkg::focus_result_t r;
    int s;
    logic cur;
    r.insert_dropped = 1'b0;
    if (in_ch.req_type == fcr_pkg::REQ_UPDATE) begin
      s = lookup(in_ch.origin_tree_id);
      if (s < 0)
        for (int i = 0; i < fcr_pkg::TABLE_DEPTH; i++)
          if (!key_used[i]) begin
            s = i;
            break;
          end
      if (s < 0) begin
        r.insert_dropped = 1'b1;
      end else begin
        key_used[s] = 1'b1;
        key_id[s] = in_ch.origin_tree_id;
        link[s] = in_ch.ref_tree_id;
        hz_id[s] = in_ch.horiz_scroll_id;
        vt_id[s] = in_ch.vert_scroll_id;
        kind_of[s] = in_ch.target_kind;
        lis_of[s] = in_ch.key_listeners;
        seq_of[s] = in_ch.entry_seq;
      end
      walk_chain(in_ch.root_tree_id);
    end else if (in_ch.req_type == fcr_pkg::REQ_REMOVE) begin
      s = lookup(in_ch.origin_tree_id);
      if (s >= 0) key_used[s] = 1'b0;
    end else if (in_ch.req_type == fcr_pkg::REQ_FOCUS) begin
      event_seq = event_seq + 32'd1;
    end
    cur = (shown_seq == event_seq);
    r.horiz_valid = cur && !listeners_on_path && horiz_now != null_id;
    r.horiz_target = horiz_now;
    r.vert_valid = cur && !listeners_on_path && vert_now != null_id;
    r.vert_target = vert_now;
    r.focus_tree = tree_now;
    r.is_current = cur;
    expected_results.push_back(r);
  endtask

  task automatic compare_result();
    fcr_tb_pkg::focus_result_t e;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result item at %0t.", $realtime);
      return;
    end
    e = expected_results.pop_front();
    if (out_ch.horiz_valid !== e.horiz_valid || out_ch.horiz_target !== e.horiz_target ||
        out_ch.vert_valid !== e.vert_valid || out_ch.vert_target !== e.vert_target ||
        out_ch.focus_tree !== e.focus_tree || out_ch.is_current !== e.is_current ||
        out_ch.insert_dropped !== e.insert_dropped) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch: expected h %b %h v %b %h tree %h cur %b drop %b,",
                 e.horiz_valid, e.horiz_target, e.vert_valid, e.vert_target,
                 e.focus_tree, e.is_current, e.insert_dropped);
        $display("          got h %b %h v %b %h tree %h cur %b drop %b",
                 out_ch.horiz_valid, out_ch.horiz_target, out_ch.vert_valid,
                 out_ch.vert_target, out_ch.focus_tree, out_ch.is_current,
                 out_ch.insert_dropped);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fcr_pkg::TABLE_DEPTH; i++) key_used[i] = 1'b0;
      null_id = '0;
      event_seq = fcr_pkg::SEQ_ONE;
      shown_seq = '0;
      listeners_on_path = 1'b0;
      tree_now = '0;
      horiz_now = '0;
      vert_now = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) null_id = cfg_wr_data;
      if (out_ch.valid && out_ch.ready) compare_result();
      if (in_ch.valid && in_ch.ready) predict_item();
    end
    pending = expected_results.size();
  end
endmodule

// File: bench/focus_chain_resolver_tb.sv
// Testbench top that drives requests and configuration into the focus chain resolver.
module focus_chain_resolver_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  int          mismatches, pending;
  int          quiet_cycles = 0;
  bit          sending_done = 1'b0;
  bit          hold_off = 1'b0;
  bit          calm = 1'b0;
  logic [31:0] tree_pool [8];

  fcr_in_if  in_ch ();
  fcr_out_if out_ch ();

  focus_chain_resolver DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  focus_chain_checker checker_inst (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.root_tree_id = '0;
    in_ch.origin_tree_id = '0;
    in_ch.target_kind = '0;
    in_ch.ref_tree_id = '0;
    in_ch.horiz_scroll_id = '0;
    in_ch.vert_scroll_id = '0;
    in_ch.key_listeners = 1'b0;
    in_ch.entry_seq = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 12);
  end

  initial begin
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(logic [1:0] req, logic [31:0] root, logic [31:0] origin,
                           logic [1:0] kind, logic [31:0] link, logic [63:0] hz,
                           logic [63:0] vt, logic lis, logic [31:0] seq);
    while (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.root_tree_id <= root;
    in_ch.origin_tree_id <= origin;
    in_ch.target_kind <= kind;
    in_ch.ref_tree_id <= link;
    in_ch.horiz_scroll_id <= hz;
    in_ch.vert_scroll_id <= vt;
    in_ch.key_listeners <= lis;
    in_ch.entry_seq <= seq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_and_config(logic [63:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    logic [31:0] a, b, c;
    logic [1:0] req, kind;
    int pick;
    a = tree_pool[$urandom_range(7)];
    b = tree_pool[$urandom_range(7)];
    c = tree_pool[$urandom_range(7)];
    pick = $urandom_range(99);
    req = pick < 65 ? fcr_pkg::REQ_UPDATE : pick < 80 ? fcr_pkg::REQ_REMOVE :
          pick < 96 ? fcr_pkg::REQ_FOCUS : fcr_pkg::REQ_NONE;
    kind = $urandom_range(99) < 45 ? fcr_pkg::KIND_REF : 2'($urandom_range(3));
    if ($urandom_range(9) == 0) begin
      a = $urandom();
      b = $urandom();
    end
    send_item(req, tree_pool[$urandom_range(1)], a, kind, b,
              $urandom_range(3) == 0 ? 64'd0 : rand64(),
              $urandom_range(3) == 0 ? 64'd0 : rand64(),
              $urandom_range(3) == 0, $urandom_range(3) == 0 ? 32'd1 : $urandom_range(9));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) tree_pool[i] = $urandom();
    tree_pool[0] = 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    drain_and_config(64'd0);
    send_item(fcr_pkg::REQ_NONE, '0, '0, fcr_pkg::KIND_NIL, '0, '0, '0, 1'b0, '0);
    send_item(fcr_pkg::REQ_UPDATE, 32'd0, 32'd0, fcr_pkg::KIND_REF, 32'd5, '0, '0, 1'b0,
              32'd0);
    send_item(fcr_pkg::REQ_UPDATE, 32'd0, 32'd5, fcr_pkg::KIND_SCROLL, '0, '1, 64'd7, 1'b0,
              32'hFFFFFFFF);
    send_item(fcr_pkg::REQ_FOCUS, '0, '0, fcr_pkg::KIND_NIL, '0, '0, '0, 1'b0, '0);
    send_item(fcr_pkg::REQ_UPDATE, 32'd0, 32'd5, fcr_pkg::KIND_SCROLL, '0, 64'd0, 64'd9,
              1'b1, 32'd2);
    send_item(fcr_pkg::REQ_UPDATE, 32'd0, 32'd5, fcr_pkg::KIND_SPARE, '0, '0, '0, 1'b0,
              32'd3);
    send_item(fcr_pkg::REQ_UPDATE, '1, '1, fcr_pkg::KIND_REF, '1, '0, '0, 1'b0, '1);
    send_item(fcr_pkg::REQ_UPDATE, 32'd9, 32'd9, fcr_pkg::KIND_NIL, '0, '0, '0, 1'b0, 32'd0);
    send_item(fcr_pkg::REQ_REMOVE, '0, 32'd5, fcr_pkg::KIND_NIL, '0, '0, '0, 1'b0, '0);
    send_item(fcr_pkg::REQ_REMOVE, '0, 32'd77, fcr_pkg::KIND_NIL, '0, '0, '0, 1'b0, '0);
    for (int i = 0; i < 18; i++)
      send_item(fcr_pkg::REQ_UPDATE, 32'd100, 32'd100 + i, fcr_pkg::KIND_REF, 32'd101 + i,
                '0, '0, 1'b0, 32'd1);
    drain_and_config('1);
    for (int i = 0; i < 20; i++)
      send_item(fcr_pkg::REQ_REMOVE, '0, i < 2 ? 32'd0 : 32'd98 + i, fcr_pkg::KIND_NIL,
                '0, '0, '0, 1'b0, '0);
    send_item(fcr_pkg::REQ_UPDATE, 32'd0, 32'd0, fcr_pkg::KIND_SCROLL, '0, '1, 64'd3, 1'b0,
              32'd1);
    calm = 1'b1;
    for (int i = 0; i < 60; i++) random_item();
    calm = 1'b0;
    for (int i = 0; i < 140; i++) random_item();
    drain_and_config(rand64());
    for (int i = 0; i < 150; i++) random_item();
    drain_and_config(64'd0);
    for (int i = 0; i < 150; i++) random_item();
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/fcr_pkg.sv
rtl/fcr_if.sv
rtl/fcr_front.sv
rtl/fcr_back.sv
rtl/focus_chain_resolver.sv
rtl/fcr_checker.sv
bench/fcr_tb_if.sv
bench/focus_chain_checker.sv
bench/focus_chain_resolver_tb.sv
